>>> rtl/core/dcqcn_pkg.sv
// shared widths, constants and types for the dcqcn rate control core
// no dependencies; imported by every module of the core
`timescale 1ns / 1ps

package dcqcn_pkg;

   // field widths
   localparam int RATE_W     = 20;
   localparam int ALPHA_W    = 17;
   localparam int INC_W      = 17;
   localparam int GAIN_W     = 4;
   localparam int CMD_W      = 2;
   localparam int FLOW_W     = 9;
   localparam int BYTES_W    = 16;
   localparam int GAP_W      = 23;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // internal widths
   localparam int IDX_MAX_W = 16;               // widest flow index (65536 flows)
   localparam int NUM_W     = 29;               // (bytes + 12) * 8000
   localparam int CUT_W     = 18;               // 131072 - alpha
   localparam int PROD_W    = RATE_W + CUT_W;
   localparam int CHK_W     = 30;               // rate * 1000, line * 999
   localparam int DIV_CNT_W = 5;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = 1;

   // arithmetic constants
   localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 17'd65536;
   localparam logic [GAP_W-1:0]   GAP_MAX       = 23'h7F_FFFF;
   localparam logic [BYTES_W:0]   BYTE_OVERHEAD = 17'd12;
   localparam logic [12:0]        BYTE_TIME_NS  = 13'd8000;
   localparam logic [CUT_W-1:0]   CUT_BASE      = 18'd131072;
   localparam int                 CUT_SHIFT     = 17;
   localparam logic [9:0]         CHK_NUM       = 10'd1000;
   localparam logic [9:0]         CHK_DEN       = 10'd999;

   // register reset values
   localparam logic [RATE_W-1:0] LINE_RATE_RST = 20'd400000;
   localparam logic [INC_W-1:0]  INC_STEP_RST  = 17'd40;
   localparam logic [RATE_W-1:0] MIN_RATE_RST  = 20'd100;
   localparam logic [GAIN_W-1:0] GAIN_RST      = 4'd4;

   typedef enum logic [CMD_W-1:0] {
      CMD_CNP   = 2'd0,
      CMD_TIMER = 2'd1,
      CMD_SEND  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_RATE = 3'd0,
      CSR_INC_STEP  = 3'd1,
      CSR_MIN_RATE  = 3'd2,
      CSR_GAIN      = 3'd3
   } csr_idx_type;

   typedef struct packed {
      logic [RATE_W-1:0] line_rate;
      logic [INC_W-1:0]  inc_step;
      logic [RATE_W-1:0] min_rate;
      logic [GAIN_W-1:0] gain_shift;
   } cfg_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [IDX_MAX_W-1:0] flow_idx;
      logic [NUM_W-1:0]     num;
   } item_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_stat_type;

   typedef struct packed {
      logic               valid;
      logic               cnp_seen;
      logic [RATE_W-1:0]  rate;
      logic [ALPHA_W-1:0] alpha;
   } entry_type;

endpackage

>>> rtl/core/dcqcn_front.sv
// front end: takes requests, folds the flow index, forms the gap numerator
// and holds them in a two-entry queue; uses dcqcn_pkg
`timescale 1ns / 1ps

module dcqcn_front import dcqcn_pkg::*; #(
   parameter int FLOWS = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [FLOW_W-1:0]   req_flow,
   input  logic [BYTES_W-1:0]  req_pkt_bytes,
   output logic                q_valid,
   output item_type            q_item,
   input  back_stat_type       back_stat
);

   localparam int IDX_W = $clog2(FLOWS);
   localparam bit FOLD  = FLOWS < (1 << FLOW_W);
   localparam logic [FLOW_W:0] MOD_K = (FLOW_W+1)'(FOLD ? FLOWS : (1 << FLOW_W));

   // remainder by the flow count, one bit per step
   function automatic logic [IDX_W-1:0] flow_index(input logic [FLOW_W-1:0] flow);
      logic [FLOW_W:0] rem;
      rem = '0;
      for (int i = FLOW_W - 1; i >= 0; i--) begin
         rem = {rem[FLOW_W-1:0], flow[i]};
         if (FOLD && rem >= MOD_K) begin
            rem = rem - MOD_K;
         end
      end
      return IDX_W'(rem);
   endfunction

   item_type             q_mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]     count_ff, count_in;
   item_type             item_in;
   logic                 push;
   logic                 pop;
   logic [BYTES_W:0]     bytes_ext;

   assign pop       = back_stat.pop;
   assign req_stall = (count_ff == (Q_PTR_W+1)'(Q_DEPTH)) || back_stat.clearing;
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      bytes_ext        = {1'b0, req_pkt_bytes} + BYTE_OVERHEAD;
      item_in.cmd      = cmd_type'(req_cmd);
      item_in.flow_idx = IDX_MAX_W'(flow_index(req_flow));
      item_in.num      = NUM_W'(bytes_ext) * NUM_W'(BYTE_TIME_NS);
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

>>> rtl/core/dcqcn_div.sv
// radix-2 restoring divider for the inter-packet gap, one quotient bit a cycle
// uses dcqcn_pkg
`timescale 1ns / 1ps

module dcqcn_div import dcqcn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  dividend,
   input  logic [RATE_W-1:0] divisor,
   output logic              done,
   output logic [NUM_W-1:0]  quotient
);

   localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(NUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RATE_W:0]      rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [RATE_W-1:0]    dvs_ff, dvs_in;
   logic [RATE_W:0]      rem_sh;
   logic                 ge;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_sh  = {rem_ff[RATE_W-1:0], quo_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

>>> rtl/core/dcqcn_back.sv
// back end: per-flow state memory, read-modify-write sequencer, gap divider
// and response register; uses dcqcn_pkg and dcqcn_div
`timescale 1ns / 1ps

module dcqcn_back import dcqcn_pkg::*; #(
   parameter int FLOWS = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                q_valid,
   input  item_type            q_item,
   output back_stat_type       back_stat,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [RATE_W-1:0]   rsp_rate_mbps,
   output logic [ALPHA_W-1:0]  rsp_alpha_q16,
   output logic                rsp_rearm_timer,
   output logic [GAP_W-1:0]    rsp_gap_ns
);

   localparam int IDX_W = $clog2(FLOWS);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_READ   = 7'b0000010,
      ST_CALC   = 7'b0000100,
      ST_CNP_WR = 7'b0001000,
      ST_TMR_WR = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic               clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0]   clr_cnt_ff, clr_cnt_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;
   logic               cnp_ff, cnp_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [CHK_W-1:0]   lhs_ff, lhs_in;
   logic [CHK_W-1:0]   rhs_ff, rhs_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]  rsp_rate_ff, rsp_rate_in;
   logic [ALPHA_W-1:0] rsp_alpha_ff, rsp_alpha_in;
   logic               rsp_rearm_ff, rsp_rearm_in;
   logic [GAP_W-1:0]   rsp_gap_ff, rsp_gap_in;

   // state memory
   entry_type          mem [FLOWS];
   entry_type          rd_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   entry_type          mem_wd;
   logic               pop;

   // datapath
   logic [RATE_W-1:0]  eff_rate;
   logic [ALPHA_W-1:0] eff_alpha;
   logic [ALPHA_W-1:0] alpha_dec;
   logic [ALPHA_W:0]   alpha_up;
   logic [ALPHA_W-1:0] alpha_cnp;
   logic [CUT_W-1:0]   cut;
   logic [RATE_W:0]    rate_sum;
   logic [RATE_W-1:0]  rate_inc;
   logic [RATE_W-1:0]  rate_cut;
   logic               out_free;

   logic               div_start;
   logic               div_done;
   logic [NUM_W-1:0]   div_quo;

   dcqcn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (rate_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign pop                = (state_ff == ST_IDLE) && q_valid && !clr_busy_ff;
   assign back_stat.pop      = pop;
   assign back_stat.clearing = clr_busy_ff;
   assign out_free           = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rate_mbps   = rsp_rate_ff;
   assign rsp_alpha_q16   = rsp_alpha_ff;
   assign rsp_rearm_timer = rsp_rearm_ff;
   assign rsp_gap_ns      = rsp_gap_ff;

   // arithmetic on the entry just read and on the working registers
   always_comb begin
      eff_rate  = (!rd_ff.valid || rd_ff.rate == '0) ? cfg.line_rate : rd_ff.rate;
      eff_alpha = rd_ff.valid ? rd_ff.alpha : ALPHA_ONE;
      alpha_dec = eff_alpha - (eff_alpha >> cfg.gain_shift);
      alpha_up  = {1'b0, alpha_dec} + {1'b0, ALPHA_ONE >> cfg.gain_shift};
      alpha_cnp = (alpha_up > {1'b0, ALPHA_ONE}) ? ALPHA_ONE : alpha_up[ALPHA_W-1:0];
      cut       = CUT_BASE - {1'b0, alpha_ff};
      rate_sum  = {1'b0, rate_ff} + (RATE_W+1)'(cfg.inc_step);
      rate_inc  = (rate_sum > {1'b0, cfg.line_rate}) ? cfg.line_rate
                                                     : rate_sum[RATE_W-1:0];
      rate_cut  = prod_ff[CUT_SHIFT +: RATE_W];
      if (rate_cut < cfg.min_rate) begin
         rate_cut = cfg.min_rate;
      end
   end

   // memory write port: clearing pass first, then the write-back states
   always_comb begin
      mem_we = 1'b0;
      mem_wa = idx_ff;
      mem_wd = '0;
      if (clr_busy_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_cnt_ff;
      end else if (state_ff == ST_CNP_WR) begin
         mem_we = 1'b1;
         mem_wd = '{valid: 1'b1, cnp_seen: 1'b1, rate: rate_cut, alpha: alpha_ff};
      end else if (state_ff == ST_TMR_WR) begin
         mem_we = 1'b1;
         mem_wd = '{valid: 1'b1, cnp_seen: 1'b0, rate: rate_ff, alpha: alpha_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (pop) begin
         rd_ff <= mem[q_item.flow_idx[IDX_W-1:0]];
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_busy_in  = clr_busy_ff;
      clr_cnt_in   = clr_cnt_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      num_in       = num_ff;
      rate_in      = rate_ff;
      alpha_in     = alpha_ff;
      cnp_in       = cnp_ff;
      prod_in      = prod_ff;
      lhs_in       = lhs_ff;
      rhs_in       = rhs_ff;
      gap_in       = gap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rate_in  = rsp_rate_ff;
      rsp_alpha_in = rsp_alpha_ff;
      rsp_rearm_in = rsp_rearm_ff;
      rsp_gap_in   = rsp_gap_ff;
      div_start    = 1'b0;

      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == IDX_W'(FLOWS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cmd_in   = q_item.cmd;
               idx_in   = q_item.flow_idx[IDX_W-1:0];
               num_in   = q_item.num;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rate_in = eff_rate;
            cnp_in  = rd_ff.cnp_seen;
            gap_in  = '0;
            unique case (cmd_ff)
               CMD_CNP:   alpha_in = alpha_cnp;
               CMD_TIMER: alpha_in = alpha_dec;
               CMD_SEND,
               CMD_NOP:   alpha_in = eff_alpha;
               default:   alpha_in = eff_alpha;
            endcase
            state_in = ST_CALC;
         end
         ST_CALC: begin
            unique case (cmd_ff)
               CMD_CNP: begin
                  prod_in  = PROD_W'(rate_ff) * PROD_W'(cut);
                  state_in = ST_CNP_WR;
               end
               CMD_TIMER: begin
                  if (cnp_ff) begin
                     cnp_in = 1'b0;
                  end else begin
                     rate_in = rate_inc;
                  end
                  state_in = ST_TMR_WR;
               end
               CMD_SEND: begin
                  if (rate_ff == '0) begin
                     gap_in   = GAP_MAX;
                     state_in = ST_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_CNP_WR: begin
            rate_in  = rate_cut;
            state_in = ST_DONE;
         end
         ST_TMR_WR: begin
            lhs_in   = CHK_W'(rate_ff) * CHK_W'(CHK_NUM);
            rhs_in   = CHK_W'(cfg.line_rate) * CHK_W'(CHK_DEN);
            state_in = ST_DONE;
         end
         ST_DIV: begin
            if (div_done) begin
               gap_in   = (div_quo > NUM_W'(GAP_MAX)) ? GAP_MAX : div_quo[GAP_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = (rate_ff == '0) ? cfg.line_rate : rate_ff;
               rsp_alpha_in = alpha_ff;
               rsp_gap_in   = gap_ff;
               unique case (cmd_ff)
                  CMD_CNP:   rsp_rearm_in = 1'b1;
                  CMD_TIMER: rsp_rearm_in = lhs_ff < rhs_ff;
                  CMD_SEND,
                  CMD_NOP:   rsp_rearm_in = 1'b0;
                  default:   rsp_rearm_in = 1'b0;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clr_busy_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_busy_ff  <= clr_busy_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      num_ff       <= num_in;
      rate_ff      <= rate_in;
      alpha_ff     <= alpha_in;
      cnp_ff       <= cnp_in;
      prod_ff      <= prod_in;
      lhs_ff       <= lhs_in;
      rhs_ff       <= rhs_in;
      gap_ff       <= gap_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_rearm_ff <= rsp_rearm_in;
      rsp_gap_ff   <= rsp_gap_in;
   end

endmodule

>>> rtl/core/dcqcn_rate_control_core.sv
// dcqcn reaction-point rate control core: top level with control registers
// a request goes through the front queue, then the back end states read, calc,
// the write-back state (cnp, timer) or the gap divider (send), and done
// one request is in the back end at a time: the next is popped only once the
// last response is registered; up to two more requests wait in the front queue
// reset is synchronous; afterwards the per-flow memory is swept once over all
// FLOWS entries (clearing pass), during which req_stall stays high
`timescale 1ns / 1ps

module dcqcn_rate_control_core import dcqcn_pkg::*; #(
   parameter int FLOWS = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [FLOW_W-1:0]     req_flow,
   input  logic [BYTES_W-1:0]    req_pkt_bytes,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [RATE_W-1:0]     rsp_rate_mbps,
   output logic [ALPHA_W-1:0]    rsp_alpha_q16,
   output logic                  rsp_rearm_timer,
   output logic [GAP_W-1:0]      rsp_gap_ns,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // control registers
   logic [RATE_W-1:0] line_rate_ff, line_rate_in;
   logic [INC_W-1:0]  inc_step_ff, inc_step_in;
   logic [RATE_W-1:0] min_rate_ff, min_rate_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   cfg_type           cfg;

   // front to back
   logic              q_valid;
   item_type          q_item;
   back_stat_type     back_stat;

   // writes are always taken; software must only write while the core is idle, which the core does not enforce
   assign csr_ready = 1'b1;

   always_comb begin
      line_rate_in = line_rate_ff;
      inc_step_in  = inc_step_ff;
      min_rate_in  = min_rate_ff;
      gain_in      = gain_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LINE_RATE: line_rate_in = csr_wdata[RATE_W-1:0];
            CSR_INC_STEP:  inc_step_in  = csr_wdata[INC_W-1:0];
            CSR_MIN_RATE:  min_rate_in  = csr_wdata[RATE_W-1:0];
            CSR_GAIN:      gain_in      = csr_wdata[GAIN_W-1:0];
            default:       ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_rate_ff <= LINE_RATE_RST;
         inc_step_ff  <= INC_STEP_RST;
         min_rate_ff  <= MIN_RATE_RST;
         gain_ff      <= GAIN_RST;
      end else begin
         line_rate_ff <= line_rate_in;
         inc_step_ff  <= inc_step_in;
         min_rate_ff  <= min_rate_in;
         gain_ff      <= gain_in;
      end
   end

   assign cfg = '{line_rate: line_rate_ff, inc_step: inc_step_ff,
                  min_rate: min_rate_ff, gain_shift: gain_ff};

   // front: accept, fold the flow index, precompute the gap numerator, queue
   dcqcn_front #(
      .FLOWS (FLOWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_flow      (req_flow),
      .req_pkt_bytes (req_pkt_bytes),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .back_stat     (back_stat)
   );

   // back: flow state read-modify-write, alpha and rate update, gap divide,
   // registered response so the queue keeps filling while rsp_stall is high
   dcqcn_back #(
      .FLOWS (FLOWS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .back_stat       (back_stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rate_mbps   (rsp_rate_mbps),
      .rsp_alpha_q16   (rsp_alpha_q16),
      .rsp_rearm_timer (rsp_rearm_timer),
      .rsp_gap_ns      (rsp_gap_ns)
   );

endmodule
